// File: design/crtt_pkg.sv
// ----------------------------------------------------------------------------
// crtt_pkg
// Shared constants and control types for the channel replay timestamp table.
// ----------------------------------------------------------------------------
package crtt_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CH_W    = 16;
	localparam int TS_W    = 64;

	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_COMMIT = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REPLAY = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic load;       // capture request, restart scan
		logic scan_step;  // examine one entry
		logic compare;    // register the timestamp compare
		logic commit;     // load result, update table
	} crtt_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} crtt_sts_t;

endpackage

// File: design/crtt_ctrl.sv
// ----------------------------------------------------------------------------
// crtt_ctrl
// Sequencer: accept a request, scan all entries, compare, deliver the result.
// ----------------------------------------------------------------------------
module crtt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  crtt_pkg::crtt_sts_t sts,
	output crtt_pkg::crtt_cmd_t cmd
);
	import crtt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.compare = 1'b1;
				state_d     = S_RESULT;
			end
			S_RESULT: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/crtt_datapath.sv
// ----------------------------------------------------------------------------
// crtt_datapath
// Entry table, request registers, sequential scan and result register.
// ----------------------------------------------------------------------------
module crtt_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crtt_pkg::crtt_cmd_t           cmd,
	output crtt_pkg::crtt_sts_t           sts,
	input  logic                          req_op,
	input  logic [crtt_pkg::CH_W-1:0]     req_channel,
	input  logic [crtt_pkg::TS_W-1:0]     req_timestamp,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [1:0]                    res_status,
	output logic                          res_hit,
	output logic [2:0]                    res_entry_index
);
	import crtt_pkg::*;

	logic [ENTRIES-1:0] entry_valid_q;
	logic [CH_W-1:0]    entry_channel_q   [ENTRIES];
	logic [TS_W-1:0]    entry_last_time_q [ENTRIES];

	logic             op_q;
	logic [CH_W-1:0]  ch_q;
	logic [TS_W-1:0]  ts_q;

	logic [IDX_W-1:0] scan_idx_q;
	logic             found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [TS_W-1:0]  match_time_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             newer_q;

	logic             scan_match;
	logic             scan_free;
	logic [1:0]       status_d;
	logic             hit_d;
	logic [IDX_W-1:0] sel_idx;
	logic [IDX_W+2:0] sel_idx_ext;
	logic             claim;
	logic             update;

	assign scan_match = entry_valid_q[scan_idx_q] && (entry_channel_q[scan_idx_q] == ch_q);
	assign scan_free  = !entry_valid_q[scan_idx_q];

	assign sts.scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));
	assign sts.out_busy  = m_tvalid && !m_tready;

	assign claim  = (op_q == OP_COMMIT) && !found_q && free_found_q;
	assign update = (op_q == OP_COMMIT) && found_q;

	always_comb begin
		hit_d    = found_q;
		status_d = ST_OK;
		sel_idx  = '0;
		if (found_q) begin
			sel_idx = match_idx_q;
			if (op_q == OP_CHECK && !newer_q) begin
				status_d = ST_REPLAY;
			end
		end else if (op_q == OP_COMMIT) begin
			if (free_found_q) begin
				sel_idx = free_idx_q;
			end else begin
				status_d = ST_FULL;
			end
		end
	end

	// widen the slot number with three zero bits; the low three bits form the result index
	assign sel_idx_ext = {3'b000, sel_idx};

	// request capture and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!sts.scan_last) begin
				scan_idx_q <= IDX_W'(scan_idx_q + 1'b1);
			end
			if (scan_match && !found_q) begin
				found_q <= 1'b1;
			end
			if (scan_free && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req_op;
			ch_q <= req_channel;
			ts_q <= req_timestamp;
		end
		if (cmd.scan_step) begin
			if (scan_match && !found_q) begin
				match_idx_q  <= scan_idx_q;
				match_time_q <= entry_last_time_q[scan_idx_q];
			end
			if (scan_free && !free_found_q) begin
				free_idx_q <= scan_idx_q;
			end
		end
		if (cmd.compare) begin
			newer_q <= (ts_q > match_time_q);
		end
	end

	// table: valid marks reset, payload written on commit only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (cmd.commit && claim) begin
			entry_valid_q[free_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (update) begin
				entry_last_time_q[match_idx_q] <= ts_q;
			end else if (claim) begin
				entry_channel_q[free_idx_q]   <= ch_q;
				entry_last_time_q[free_idx_q] <= ts_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status      <= status_d;
			res_hit         <= hit_d;
			res_entry_index <= sel_idx_ext[2:0];
		end
	end

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_status == ST_OK || res_status == ST_REPLAY || res_status == ST_FULL))
		else $error("result status out of range");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_status == ST_FULL) |-> (!res_hit && res_entry_index == 3'd0))
		else $error("table full reported with an entry");

	a_claim_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && claim) |=> entry_valid_q[$past(free_idx_q)])
		else $error("claimed entry not marked valid");

	a_commit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(m_tvalid && !m_tready))
		else $error("result overwritten before transfer");

endmodule

// File: design/channel_replay_timestamp_table.sv
// ----------------------------------------------------------------------------
// channel_replay_timestamp_table
// Per-channel anti-replay table: check a timestamp against the last one
// stored for its channel, or commit a timestamp for a channel.
// ----------------------------------------------------------------------------
//  channel | direction | fields (low bit first)
//  s_      | in        | tuser: operation; tdata: channel[15:0], timestamp[79:16]
//  m_      | out       | tdata: status[1:0], hit[2], entry_index[5:3], zero pad
//
//  Each item is scanned over all ENTRIES entries, one entry per cycle, then
//  compared, then committed to the output register and the table.
//  A new item is taken once the previous result is loaded in the output
//  register, so one result may wait while the next item is scanned.
//  A stalled output holds the sequencer before the table update.
//  Reset clears all valid marks at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module channel_replay_timestamp_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // channel[15:0], timestamp[79:16]
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // status[1:0], hit[2], entry_index[5:3], 0[7:6]
);
	import crtt_pkg::*;

	crtt_cmd_t  cmd;
	crtt_sts_t  sts;
	logic [1:0] res_status;
	logic       res_hit;
	logic [2:0] res_entry_index;

	crtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	crtt_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_op          (s_tuser),
		.req_channel     (s_tdata[CH_W-1:0]),
		.req_timestamp   (s_tdata[CH_W+TS_W-1:CH_W]),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.res_status      (res_status),
		.res_hit         (res_hit),
		.res_entry_index (res_entry_index)
	);

	assign m_tdata = {2'b00, res_entry_index, res_hit, res_status};

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives check and commit frames into the channel replay timestamp table and
// compares every verdict with a scoreboard that keeps its own copy of the
// table. Directed cases cover empty lookups, equal and older timestamps,
// filling the table and the full case; random traffic follows, with random
// gaps on both sides, a long output stall and pauses of the sender.
// ----------------------------------------------------------------------------
module testbench;
	import crtt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = ENTRIES + 8;

	typedef struct packed {
		logic [1:0] status;
		logic       hit;
		logic [2:0] entry_index;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;   // channel[15:0], timestamp[79:16]
	logic        s_tuser = 1'b0; // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // status[1:0], hit[2], entry_index[5:3], 0[7:6]

	// scoreboard copy of the table
	logic            known_valid [ENTRIES];
	logic [CH_W-1:0] known_chan  [ENTRIES];
	logic [TS_W-1:0] known_stamp [ENTRIES];

	verdict_t verdicts_due [$];
	int       fail_count = 0;
	int       quiet_cycles = 0;
	int       sink_hold = 0;
	bit       src_burst = 1'b0;
	bit       sink_burst = 1'b0;
	int       op_tally [2] = '{0, 0};
	int       status_tally [4] = '{0, 0, 0, 0};

	channel_replay_timestamp_table uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #6 clk = ~clk;

	// lowest valid slot holding the channel, or -1
	function automatic int find_entry(input logic [CH_W-1:0] ch);
		int slot;
		slot = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (known_valid[i] && known_chan[i] == ch)
				slot = i;
		end
		return slot;
	endfunction

	function automatic int find_free();
		int slot;
		slot = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!known_valid[i])
				slot = i;
		end
		return slot;
	endfunction

	// verdict for one frame; commits update the scoreboard table
	function automatic verdict_t judge_frame(input logic op, input logic [CH_W-1:0] ch,
			input logic [TS_W-1:0] ts);
		verdict_t v;
		int slot;
		v.status = ST_OK;
		v.hit = 1'b0;
		v.entry_index = 3'd0;
		slot = find_entry(ch);
		if (slot >= 0) begin
			v.hit = 1'b1;
			v.entry_index = 3'(slot);
			if (op == OP_CHECK) begin
				if (ts <= known_stamp[slot])
					v.status = ST_REPLAY;
			end else begin
				known_stamp[slot] = ts;
			end
		end else if (op == OP_COMMIT) begin
			slot = find_free();
			if (slot < 0) begin
				v.status = ST_FULL;
			end else begin
				known_valid[slot] = 1'b1;
				known_chan[slot] = ch;
				known_stamp[slot] = ts;
				v.entry_index = 3'(slot);
			end
		end
		return v;
	endfunction

	task automatic send_frame(input logic op, input logic [CH_W-1:0] ch,
			input logic [TS_W-1:0] ts);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {ts, ch};
		do @(posedge clk); while (!s_tready);
		verdicts_due.push_back(judge_frame(op, ch, ts));
		op_tally[op]++;
	endtask

	// stop offering and wait for every outstanding verdict
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (verdicts_due.size() != 0);
	endtask

	task automatic test_empty_lookup();
		send_frame(OP_CHECK, 16'h0000, 64'h0);
		send_frame(OP_CHECK, 16'hFFFF, '1);
		drain();
	endtask

	task automatic test_claim_and_replay();
		send_frame(OP_COMMIT, 16'hFFFF, '1);
		send_frame(OP_CHECK, 16'hFFFF, '1);     // equal: rejected
		send_frame(OP_CHECK, 16'hFFFF, 64'h0);  // older: rejected
		send_frame(OP_COMMIT, 16'hFFFF, 64'h0); // overwrite with older value
		send_frame(OP_CHECK, 16'hFFFF, 64'h0);
		send_frame(OP_CHECK, 16'hFFFF, 64'h1);
		send_frame(OP_CHECK, 16'hFFFF, '1);
		drain();
	endtask

	task automatic test_fill_table();
		logic [CH_W-1:0] ch;
		logic [TS_W-1:0] ts;
		for (int i = 0; i < ENTRIES - 1; i++) begin
			ch = {i[7:0], ~i[7:0]};
			case (i % 3)
				0: ts = '0;
				1: ts = '1;
				default: ts = {$urandom, $urandom};
			endcase
			send_frame(OP_COMMIT, ch, ts);
		end
		send_frame(OP_COMMIT, 16'h1234, 64'h55AA_55AA_55AA_55AA); // no free slot
		send_frame(OP_CHECK, 16'h1234, 64'h0);
		send_frame(OP_COMMIT, 16'h00FF, 64'd42);
		drain();
	endtask

	// pick a timestamp near the stored one so both verdicts show up
	function automatic logic [TS_W-1:0] pick_stamp(input logic [CH_W-1:0] ch);
		logic [TS_W-1:0] base;
		int slot;
		slot = find_entry(ch);
		base = (slot >= 0) ? known_stamp[slot] : {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return base;
			1: return base + $urandom_range(1, 3);
			2: return base - $urandom_range(1, 3);
			3: return {$urandom, $urandom};
			4: return '1;
			default: return '0;
		endcase
	endfunction

	function automatic logic [CH_W-1:0] pick_channel();
		int slot;
		slot = $urandom_range(0, ENTRIES - 1);
		if ($urandom_range(0, 9) < 8 && known_valid[slot])
			return known_chan[slot];
		return CH_W'($urandom);
	endfunction

	task automatic test_output_backlog();
		logic [CH_W-1:0] ch;
		sink_hold = 60;
		src_burst = 1'b1;
		for (int n = 0; n < 12; n++) begin
			ch = pick_channel();
			send_frame(logic'($urandom_range(0, 1)), ch, pick_stamp(ch));
		end
		src_burst = 1'b0;
		drain();
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [CH_W-1:0] ch;
		for (int n = 0; n < n_items; n++) begin
			if (n % 100 == 0) begin
				src_burst = ($urandom_range(0, 3) == 0);
				sink_burst = ($urandom_range(0, 3) == 0);
			end
			ch = pick_channel();
			send_frame(logic'($urandom_range(0, 1)), ch, pick_stamp(ch));
			if (n % 250 == 249)
				drain();
		end
		src_burst = 1'b0;
		sink_burst = 1'b0;
		drain();
	endtask

	// result sink: random ready gaps, long holds on request, verdict check
	initial begin : result_sink
		int gap;
		verdict_t want;
		@(posedge clk iff arst_n);
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			gap = 0;
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$error("result 0x%02h with no verdict pending", m_tdata);
					fail_count++;
				end else begin
					want = verdicts_due.pop_front();
					status_tally[want.status]++;
					if (m_tdata[1:0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
						fail_count++;
					end
					if (m_tdata[2] !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, m_tdata[2]);
						fail_count++;
					end
					if (m_tdata[5:3] !== want.entry_index) begin
						$error("entry_index: expected %0d, got %0d", want.entry_index,
							m_tdata[5:3]);
						fail_count++;
					end
					if (m_tdata[7:6] !== 2'b00) begin
						$error("pad: expected 0, got %0d", m_tdata[7:6]);
						fail_count++;
					end
				end
				gap = sink_burst ? 0 : $urandom_range(0, 6);
			end
			if (sink_hold > 0) begin
				gap = gap + sink_hold;
				sink_hold = 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			known_valid[i] = 1'b0;
			known_chan[i] = '0;
			known_stamp[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_lookup();
		test_claim_and_replay();
		test_fill_table();
		test_output_backlog();
		test_random_traffic(1000);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("frames: %0d checks, %0d commits", op_tally[OP_CHECK], op_tally[OP_COMMIT]);
		$display("verdicts: %0d accepted, %0d replays, %0d table full",
			status_tally[ST_OK], status_tally[ST_REPLAY], status_tally[ST_FULL]);
		if (fail_count == 0 && verdicts_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/crtt_pkg.sv
design/crtt_ctrl.sv
design/crtt_datapath.sv
design/channel_replay_timestamp_table.sv
test/testbench.sv
